/* rtl/rfp_pkg.sv */
// rfp_pkg: shared types and codes for the ring fifo with peek and drain
// no dependencies

package rfp_pkg;

    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int OFFSET_W = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 11;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [LEVEL_W-1:0]  level_t;

    localparam func_t FUNC_WRITE = 2'd0;
    localparam func_t FUNC_PEEK  = 2'd1;
    localparam func_t FUNC_DRAIN = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOSPACE = 2'd1;
    localparam status_t ST_INVALID = 2'd2;

endpackage

/* rtl/rfp_if.sv */
// rfp_if: request and response channels of the ring fifo (valid/ready)
// depends on rfp_pkg

interface rfp_req_if;
    import rfp_pkg::*;

    logic    valid;
    logic    ready;
    func_t   func;
    data_t   data;
    offset_t offset;
    count_t  count;

    modport source (output valid, output func, output data, output offset,
                    output count, input ready);
    modport sink   (input valid, input func, input data, input offset,
                    input count, output ready);
endinterface

interface rfp_rsp_if;
    import rfp_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    data_t   read_data;
    level_t  level;

    modport source (output valid, output status, output read_data, output level,
                    input ready);
    modport sink   (input valid, input status, input read_data, input level,
                    output ready);
endinterface

/* rtl/ring_fifo_peek_drain.sv */
// ring_fifo_peek_drain: ring buffer with write, peek at offset and drain of n elements
// depends on rfp_pkg and the channel interfaces in rfp_if
// latency: the result is valid in the cycle after the request transfer
// throughput: one request per cycle while the response is taken or absent; the single
// result register and the registered read port of the element store set that figure
// reset: pointers cleared and buffer marked empty at once; the element
// store is not cleared and holds nothing defined until written

module ring_fifo_peek_drain #(
    parameter int DEPTH     = 1024,
    parameter int ELEM_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    rfp_req_if.sink   req,
    rfp_rsp_if.source rsp
);
    import rfp_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int LVL_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = ((LVL_W > COUNT_W) ? LVL_W : COUNT_W) + 1;

    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [WIDE_W-1:0]    wide_t;
    typedef logic [ELEM_BITS-1:0] elem_t;

    localparam wide_t DEPTH_W = WIDE_W'(DEPTH);

    elem_t   mem [DEPTH];
    elem_t   rdata_reg;

    ptr_t    rd_ptr_reg, rd_ptr_next;
    ptr_t    wr_ptr_reg, wr_ptr_next;
    logic    empty_reg, empty_next;

    logic    rsp_valid_reg;
    status_t status_reg, status_next;
    level_t  level_reg, level_next;
    logic    rd_ok_reg, rd_ok_next;

    logic    xfer;
    logic    wr_en;
    wide_t   rp_w, wp_w, lvl_w, peek_dist, count_w;
    wide_t   peek_sum, drain_sum, wr_sum;
    ptr_t    peek_addr;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign xfer      = req.valid && req.ready;

    assign rp_w      = WIDE_W'(rd_ptr_reg);
    assign wp_w      = WIDE_W'(wr_ptr_reg);
    assign peek_dist = WIDE_W'(req.offset);
    assign count_w   = WIDE_W'(req.count);

    // current fill level
    always_comb
    begin
        priority if (empty_reg)
        begin
            lvl_w = '0;
        end
        else if (wp_w > rp_w)
        begin
            lvl_w = wp_w - rp_w;
        end
        else
        begin
            lvl_w = DEPTH_W - rp_w + wp_w;
        end
    end

    // pointer advance with wrap
    assign peek_sum  = rp_w + peek_dist;
    assign drain_sum = rp_w + count_w;
    assign wr_sum    = wp_w + WIDE_W'(1);

    always_comb
    begin
        if (peek_sum >= DEPTH_W)
        begin
            peek_addr = PTR_W'(peek_sum - DEPTH_W);
        end
        else
        begin
            peek_addr = PTR_W'(peek_sum);
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        empty_next  = empty_reg;
        status_next = ST_INVALID;
        level_next  = LEVEL_W'(lvl_w);
        rd_ok_next  = 1'b0;
        wr_en       = 1'b0;
        unique case (req.func)
            FUNC_WRITE:
            begin
                if (lvl_w >= DEPTH_W)
                begin
                    status_next = ST_NOSPACE;
                end
                else
                begin
                    wr_en       = xfer;
                    wr_ptr_next = (wr_sum >= DEPTH_W) ? PTR_W'(wr_sum - DEPTH_W)
                                                      : PTR_W'(wr_sum);
                    empty_next  = 1'b0;
                    status_next = ST_OK;
                    level_next  = LEVEL_W'(lvl_w + WIDE_W'(1));
                end
            end
            FUNC_PEEK:
            begin
                if (peek_dist < lvl_w)
                begin
                    status_next = ST_OK;
                    rd_ok_next  = 1'b1;
                end
            end
            FUNC_DRAIN:
            begin
                if (count_w <= lvl_w)
                begin
                    if (count_w == lvl_w)
                    begin
                        empty_next = 1'b1;
                    end
                    rd_ptr_next = (drain_sum >= DEPTH_W) ? PTR_W'(drain_sum - DEPTH_W)
                                                         : PTR_W'(drain_sum);
                    status_next = ST_OK;
                    level_next  = LEVEL_W'(lvl_w - count_w);
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= ELEM_BITS'(req.data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer && rd_ok_next)
        begin
            rdata_reg <= mem[peek_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            empty_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                empty_reg  <= empty_next;
                rd_ok_reg  <= rd_ok_next;
            end
            if (xfer)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            status_reg <= status_next;
            level_reg  <= level_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.level     = level_reg;
    assign rsp.read_data = rd_ok_reg ? DATA_W'(rdata_reg) : '0;

endmodule
